// ----- hdl/pwm_timer_setting_calculator_macros.svh -----
// ----------------------------------------------------------------------------
// PWM timer setting calculator assertion macros
// Shared concurrent check macros; empty when built for synthesis.
// ----------------------------------------------------------------------------
`ifndef PWM_TIMER_SETTING_CALCULATOR_MACROS_SVH
`define PWM_TIMER_SETTING_CALCULATOR_MACROS_SVH

`ifndef SYNTHESIS

`define PTSC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

`define PTSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define PTSC_ASSERT_SAME(label, clk, rst_n, ante, cons)

`define PTSC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- hdl/pwmtsc_pkg.sv -----
// ----------------------------------------------------------------------------
// PWM timer setting calculator package
// Widths, reset values, codes and defaults shared by the calculator.
// ----------------------------------------------------------------------------
`default_nettype none

package pwmtsc_pkg;

    localparam int DEF_NUM_CHANNELS = 4;
    localparam int DEF_NARROW_LIMIT = 65535;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 88;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int UNIT_W     = 48;

    localparam logic [27:0] CLOCK_RESET = 28'd84000000;
    localparam logic [14:0] FULL_DUTY   = 15'd25600;
    localparam logic [15:0] PSC_MAX     = 16'hFFFF;

    typedef enum logic [1:0] {
        KIND_FREQ_DUTY = 2'd0,
        KIND_DUTY      = 2'd1,
        KIND_FREQ_KEEP = 2'd2
    } t_kind;

    typedef enum logic {
        REG_CLOCK = 1'b0,
        REG_WIDE  = 1'b1
    } t_reg;

endpackage

`default_nettype wire

// ----- hdl/pwm_timer_setting_calculator.sv -----
// ----------------------------------------------------------------------------
// PWM timer setting calculator
// Prescaler, autoreload and compare from a frequency and duty request.
// ----------------------------------------------------------------------------
// One item at a time through one bit-serial shift-add multiplier / restoring
// divider, one bit per cycle. The next item is accepted while the last result
// is first offered; a held earlier result stalls it.
// Synchronous active-low reset: clock 84 MHz, narrow counter, all settings 0.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pwm_timer_setting_calculator_macros.svh"

module pwm_timer_setting_calculator #(
    parameter int NUM_CHANNELS = pwmtsc_pkg::DEF_NUM_CHANNELS,
    parameter int NARROW_LIMIT = pwmtsc_pkg::DEF_NARROW_LIMIT
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [pwmtsc_pkg::CFG_ADDR_W-1:0]  paddr,
    input  wire logic [pwmtsc_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic      [pwmtsc_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                                    pready,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // channel[1:0], freq_hz[29:2], duty_q8[45:30], zero fill
    input  wire logic [pwmtsc_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // kind[1:0]
    input  wire logic [1:0]                         s_axis_tuser,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // prescaler[15:0], autoreload[47:16], compare[79:48], channel_out[81:80], zero fill
    output logic      [pwmtsc_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

    import pwmtsc_pkg::*;

    localparam int CH_IW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [UNIT_W-1:0] PSC_DIV = UNIT_W'(NARROW_LIMIT + 1);
    localparam logic [31:0]       NARROW_MAX = 32'(NARROW_LIMIT);

    typedef enum logic [3:0] {
        S_IDLE, S_RUN, S_K1, S_K2, S_K3, S_F1, S_F2, S_F3, S_F4, S_F5,
        S_C1, S_C2, S_C3, S_DONE
    } t_state;

    typedef enum logic {
        OP_MUL,
        OP_DIV
    } t_op;

    t_state             r_state;
    t_state             r_ret;
    t_op                r_op;
    logic [5:0]         r_cnt;
    logic [UNIT_W-1:0]  r_a;
    logic [UNIT_W-1:0]  r_b;
    logic [UNIT_W-1:0]  r_acc;

    logic [27:0]        r_clk;
    logic               r_wide;
    logic [15:0]        r_psc;
    logic [31:0]        r_period;
    logic [31:0]        r_cmp [NUM_CHANNELS];

    logic [1:0]         r_chan;
    logic [27:0]        r_freq;
    logic [14:0]        r_duty;
    logic               r_o_valid;
    logic [OUT_DATA_W-1:0] r_o_data;

    logic [27:0]        w_clk_eff;
    logic [27:0]        w_f;
    logic               w_ch_ok;
    logic [CH_IW-1:0]   w_idx;
    logic [31:0]        w_cmp;
    logic [UNIT_W:0]    w_rem_sh;
    logic [UNIT_W:0]    w_diff;
    logic               w_ge;
    logic [32:0]        w_den;
    logic [UNIT_W-1:0]  w_keep_num;
    logic [15:0]        w_in_duty;
    logic [14:0]        w_duty_sat;
    logic [15:0]        w_psc_sat;
    logic [27:0]        w_total;
    logic               w_cfg_wr;

    assign w_clk_eff = (r_clk == '0) ? 28'd1 : r_clk;
    assign w_f = (r_freq == '0) ? 28'd1 : ((r_freq > w_clk_eff) ? w_clk_eff : r_freq);

    assign w_ch_ok = (32'(r_chan) < 32'(NUM_CHANNELS));
    assign w_idx   = CH_IW'(r_chan);
    assign w_cmp   = w_ch_ok ? r_cmp[w_idx] : 32'd0;

    assign w_rem_sh = {r_acc, r_a[UNIT_W-1]};
    assign w_ge     = (w_rem_sh >= {1'b0, r_b});
    assign w_diff   = w_rem_sh - {1'b0, r_b};

    assign w_den      = {1'b0, r_period} + 33'd1;
    assign w_keep_num = r_acc + UNIT_W'(w_den[32:1]);

    assign w_in_duty  = s_axis_tdata[45:30];
    assign w_duty_sat = w_in_duty[15] ? 15'd0 :
                        ((w_in_duty[14:0] > FULL_DUTY) ? FULL_DUTY : w_in_duty[14:0]);

    assign w_total   = r_a[27:0];
    assign w_psc_sat = (r_a > UNIT_W'(PSC_MAX)) ? PSC_MAX : r_a[15:0];

    assign w_cfg_wr = psel && penable && pwrite && pready;

    assign pready = 1'b1;
    assign prdata = (t_reg'(paddr[2]) == REG_WIDE) ? CFG_DATA_W'(r_wide) : CFG_DATA_W'(r_clk);

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = r_o_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ret     <= S_IDLE;
            r_op      <= OP_MUL;
            r_cnt     <= '0;
            r_clk     <= CLOCK_RESET;
            r_wide    <= 1'b0;
            r_psc     <= '0;
            r_period  <= '0;
            r_o_valid <= 1'b0;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_cmp[i] <= '0;
            end
        end else begin
            if (w_cfg_wr) begin
                case (t_reg'(paddr[2]))
                    REG_CLOCK: r_clk  <= pwdata[27:0];
                    REG_WIDE:  r_wide <= pwdata[0];
                    default:   r_wide <= r_wide;
                endcase
            end

            if (r_o_valid && m_axis_tready && (r_state != S_DONE)) begin
                r_o_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_chan <= s_axis_tdata[1:0];
                        r_freq <= s_axis_tdata[29:2];
                        r_duty <= w_duty_sat;
                        case (t_kind'(s_axis_tuser))
                            KIND_FREQ_DUTY: r_state <= S_F1;
                            KIND_DUTY:      r_state <= S_C1;
                            KIND_FREQ_KEEP: r_state <= S_K1;
                            default:        r_state <= S_DONE;
                        endcase
                    end
                end
                S_RUN: begin
                    if (r_op == OP_MUL) begin
                        if (r_a[0]) begin
                            r_acc <= r_acc + r_b;
                        end
                        r_a <= r_a >> 1;
                        r_b <= r_b << 1;
                    end else begin
                        r_acc <= w_ge ? w_diff[UNIT_W-1:0] : w_rem_sh[UNIT_W-1:0];
                        r_a   <= {r_a[UNIT_W-2:0], w_ge};
                    end
                    r_cnt <= r_cnt - 6'd1;
                    if (r_cnt == 6'd1) begin
                        r_state <= r_ret;
                    end
                end
                S_K1: begin
                    if (r_period == '0) begin
                        r_duty  <= '0;
                        r_state <= S_F1;
                    end else begin
                        r_a     <= UNIT_W'(FULL_DUTY);
                        r_b     <= UNIT_W'(w_cmp);
                        r_acc   <= '0;
                        r_op    <= OP_MUL;
                        r_cnt   <= 6'd15;
                        r_ret   <= S_K2;
                        r_state <= S_RUN;
                    end
                end
                S_K2: begin
                    r_a     <= {w_keep_num[UNIT_W-2:0], 1'b0};
                    r_b     <= UNIT_W'(w_den);
                    r_acc   <= '0;
                    r_op    <= OP_DIV;
                    r_cnt   <= 6'd47;
                    r_ret   <= S_K3;
                    r_state <= S_RUN;
                end
                S_K3: begin
                    r_duty  <= (r_a > UNIT_W'(FULL_DUTY)) ? FULL_DUTY : r_a[14:0];
                    r_state <= S_F1;
                end
                S_F1: begin
                    r_a     <= {w_clk_eff, 20'd0};
                    r_b     <= UNIT_W'(w_f);
                    r_acc   <= '0;
                    r_op    <= OP_DIV;
                    r_cnt   <= 6'd28;
                    r_ret   <= S_F2;
                    r_state <= S_RUN;
                end
                S_F2: begin
                    if (r_wide || (32'(w_total) <= NARROW_MAX)) begin
                        r_psc    <= '0;
                        r_period <= 32'(w_total - 28'd1);
                        r_state  <= S_C1;
                    end else begin
                        r_a     <= {w_total, 20'd0};
                        r_b     <= PSC_DIV;
                        r_acc   <= '0;
                        r_op    <= OP_DIV;
                        r_cnt   <= 6'd28;
                        r_ret   <= S_F3;
                        r_state <= S_RUN;
                    end
                end
                S_F3: begin
                    r_psc   <= w_psc_sat;
                    r_a     <= UNIT_W'({1'b0, w_psc_sat} + 17'd1);
                    r_b     <= UNIT_W'(w_f);
                    r_acc   <= '0;
                    r_op    <= OP_MUL;
                    r_cnt   <= 6'd17;
                    r_ret   <= S_F4;
                    r_state <= S_RUN;
                end
                S_F4: begin
                    r_a     <= {w_clk_eff, 20'd0};
                    r_b     <= r_acc;
                    r_acc   <= '0;
                    r_op    <= OP_DIV;
                    r_cnt   <= 6'd28;
                    r_ret   <= S_F5;
                    r_state <= S_RUN;
                end
                S_F5: begin
                    r_period <= (r_a == '0) ? 32'd0 : (r_a[31:0] - 32'd1);
                    r_state  <= S_C1;
                end
                S_C1: begin
                    r_a     <= UNIT_W'(r_duty);
                    r_b     <= UNIT_W'(w_den);
                    r_acc   <= '0;
                    r_op    <= OP_MUL;
                    r_cnt   <= 6'd15;
                    r_ret   <= S_C2;
                    r_state <= S_RUN;
                end
                S_C2: begin
                    r_a     <= r_acc;
                    r_b     <= UNIT_W'(FULL_DUTY);
                    r_acc   <= '0;
                    r_op    <= OP_DIV;
                    r_cnt   <= 6'd48;
                    r_ret   <= S_C3;
                    r_state <= S_RUN;
                end
                S_C3: begin
                    if (w_ch_ok) begin
                        r_cmp[w_idx] <= r_a[31:0];
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_o_valid || m_axis_tready) begin
                        r_o_data  <= {6'd0, r_chan, w_cmp, r_period, r_psc};
                        r_o_valid <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `PTSC_ASSERT_SAME(a_run_count, i_clk, i_rst_n, r_state == S_RUN, r_cnt != 6'd0)
    `PTSC_ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n,
        s_axis_tvalid && s_axis_tready, r_state != S_IDLE)
    `PTSC_ASSERT_SAME(a_result_from_done, i_clk, i_rst_n,
        $rose(r_o_valid), $past(r_state == S_DONE))
    `PTSC_ASSERT_NEXT(a_stall_holds_done, i_clk, i_rst_n,
        r_state == S_DONE && r_o_valid && !m_axis_tready, r_state == S_DONE)

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PWM timer setting calculator testbench
// Streams frequency and duty requests through the calculator under random
// source gaps and sink stalls, with one long sink hold-off. Timer clock and
// counter width are changed between phases over the APB port. Every result
// is checked field by field against an in-bench model of the prescaler,
// autoreload and compare arithmetic.
// ----------------------------------------------------------------------------

module tb_top;

    import pwmtsc_pkg::*;

    localparam logic [1:0] KIND_IDLE   = 2'd3;
    localparam int         CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  channel;
        logic [27:0] freq_hz;
        logic [15:0] duty_q8;
    } t_pwm_request;

    typedef struct packed {
        logic [15:0] prescaler;
        logic [31:0] autoreload;
        logic [31:0] compare;
        logic [1:0]  channel;
    } t_pwm_setting;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr   = '0;
    logic [CFG_DATA_W-1:0] pwdata  = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [1:0]            s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    t_pwm_request requests_pending[$];
    t_pwm_setting settings_due[$];

    // model state
    logic [27:0] cfg_clock = CLOCK_RESET;
    logic        cfg_wide  = 1'b0;
    logic [15:0] psc_now   = '0;
    logic [31:0] arr_now   = '0;
    logic [31:0] cmp_mem[DEF_NUM_CHANNELS] = '{default: '0};

    int   error_count  = 0;
    int   cycle_count  = 0;
    logic steady_phase = 1'b0;
    logic hold_request = 1'b0;
    logic hold_served  = 1'b0;
    int   src_gap      = 0;
    int   src_calm     = 0;
    int   sink_gap     = 0;
    int   sink_calm    = 0;
    int   sink_hold    = 0;

    pwm_timer_setting_calculator i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #4 i_clk = ~i_clk;

    function automatic logic [31:0] duty_limit(input logic [15:0] raw);
        if (raw[15]) begin
            return 32'd0;
        end
        return (raw > 16'(FULL_DUTY)) ? 32'(FULL_DUTY) : 32'(raw);
    endfunction

    function automatic logic [31:0] compare_at(input logic [31:0] period,
                                               input logic [31:0] duty);
        logic [63:0] prod;
        prod = (64'(period) + 64'd1) * 64'(duty);
        return 32'(prod / 64'(FULL_DUTY));
    endfunction

    function automatic void retime(input logic [27:0] freq);
        logic [63:0] clk_hz;
        logic [63:0] f;
        logic [63:0] total;
        logic [63:0] psc;
        logic [63:0] q;
        clk_hz = (cfg_clock == 28'd0) ? 64'd1 : 64'(cfg_clock);
        f = 64'(freq);
        if (f < 64'd1) f = 64'd1;
        if (f > clk_hz) f = clk_hz;
        total = clk_hz / f;
        if (total <= 64'(DEF_NARROW_LIMIT) || cfg_wide) begin
            psc_now = 16'd0;
            arr_now = 32'(total - 64'd1);
        end else begin
            psc = total / (64'(DEF_NARROW_LIMIT) + 64'd1);
            if (psc > 64'(PSC_MAX)) psc = 64'(PSC_MAX);
            q = clk_hz / ((psc + 64'd1) * f);
            psc_now = 16'(psc);
            arr_now = (q == 64'd0) ? 32'd0 : 32'(q - 64'd1);
        end
    endfunction

    function automatic void predict_setting(input t_pwm_request r);
        logic [63:0]  den;
        logic [63:0]  d;
        logic [31:0]  duty;
        t_pwm_setting s;
        if (r.kind == KIND_FREQ_DUTY) begin
            duty = duty_limit(r.duty_q8);
            retime(r.freq_hz);
            cmp_mem[r.channel] = compare_at(arr_now, duty);
        end else if (r.kind == KIND_DUTY) begin
            duty = duty_limit(r.duty_q8);
            cmp_mem[r.channel] = compare_at(arr_now, duty);
        end else if (r.kind == KIND_FREQ_KEEP) begin
            d = 64'd0;
            if (arr_now != 32'd0) begin
                den = 64'(arr_now) + 64'd1;
                d = (64'(cmp_mem[r.channel]) * 64'(FULL_DUTY) + den / 64'd2) / den;
                if (d > 64'(FULL_DUTY)) d = 64'(FULL_DUTY);
            end
            retime(r.freq_hz);
            cmp_mem[r.channel] = compare_at(arr_now, 32'(d));
        end
        s.prescaler  = psc_now;
        s.autoreload = arr_now;
        s.compare    = cmp_mem[r.channel];
        s.channel    = r.channel;
        settings_due.push_back(s);
    endfunction

    function automatic void check_field(input string label, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
            error_count++;
        end
    endfunction

    function automatic void add_request(input logic [1:0] kind, input logic [1:0] channel,
                                        input logic [27:0] freq, input logic [15:0] duty);
        t_pwm_request r;
        r.kind    = kind;
        r.channel = channel;
        r.freq_hz = freq;
        r.duty_q8 = duty;
        requests_pending.push_back(r);
    endfunction

    function automatic void add_random_requests(input int count);
        logic [1:0]  kind;
        logic [27:0] freq;
        logic [15:0] duty;
        int          pick;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 19);
            if (pick < 8) kind = KIND_FREQ_DUTY;
            else if (pick < 13) kind = KIND_DUTY;
            else if (pick < 19) kind = KIND_FREQ_KEEP;
            else kind = KIND_IDLE;
            case ($urandom_range(0, 7))
                0: freq = 28'($urandom_range(0, 20));
                1: freq = 28'($urandom_range(1, 2000));
                2: freq = 28'($urandom_range(1000, 200000));
                3: freq = 28'(cfg_clock - 28'($urandom_range(0, 3)));
                4: freq = 28'(cfg_clock / 28'($urandom_range(65530, 65540)))
                          + 28'($urandom_range(0, 2));
                7: freq = 28'($urandom_range(1, 100000000));
                default: freq = 28'($urandom());
            endcase
            case ($urandom_range(0, 5))
                0: duty = 16'($urandom());
                1: begin
                    case ($urandom_range(0, 5))
                        0: duty = 16'd0;
                        1: duty = 16'(FULL_DUTY);
                        2: duty = 16'(FULL_DUTY) + 16'd1;
                        3: duty = 16'hFFFF;
                        4: duty = 16'h8000;
                        default: duty = 16'h7FFF;
                    endcase
                end
                default: duty = 16'($urandom_range(0, 25600));
            endcase
            add_request(kind, 2'($urandom_range(0, 3)), freq, duty);
        end
    endfunction

    task automatic write_reg(input t_reg idx, input logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_timer(input logic [27:0] clk_hz, input logic wide);
        write_reg(REG_CLOCK, {4'($urandom_range(0, 15)), clk_hz});
        cfg_clock = clk_hz;
        write_reg(REG_WIDE, ($urandom() & ~32'd1) | 32'(wide));
        cfg_wide = wide;
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        while (requests_pending.size() != 0 || s_axis_tvalid || settings_due.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic run_phase(input logic [27:0] clk_hz, input logic wide, input int count);
        set_timer(clk_hz, wide);
        add_random_requests(count);
        wait_idle();
    endtask

    // request source
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (src_calm > 0) src_calm--;
            if (src_gap > 0) begin
                src_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (!steady_phase && src_calm == 0 && $urandom_range(0, 9) == 0) begin
                src_gap = $urandom_range(0, 9);
                s_axis_tvalid <= 1'b0;
            end else if (requests_pending.size() != 0) begin
                if (src_calm == 0 && $urandom_range(0, 39) == 0)
                    src_calm = $urandom_range(20, 100);
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {2'b00, requests_pending[0].duty_q8,
                                  requests_pending[0].freq_hz, requests_pending[0].channel};
                s_axis_tuser  <= requests_pending[0].kind;
                void'(requests_pending.pop_front());
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result sink
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (sink_hold > 0) begin
            sink_hold--;
            m_axis_tready <= 1'b0;
        end else if (hold_request && !hold_served) begin
            hold_served = 1'b1;
            sink_hold = 599;
            m_axis_tready <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap--;
            m_axis_tready <= 1'b0;
        end else begin
            if (sink_calm > 0) sink_calm--;
            if (!steady_phase && sink_calm == 0 && $urandom_range(0, 9) == 0) begin
                sink_gap = $urandom_range(0, 9);
                m_axis_tready <= 1'b0;
            end else begin
                if (sink_calm == 0 && $urandom_range(0, 49) == 0)
                    sink_calm = $urandom_range(20, 150);
                m_axis_tready <= 1'b1;
            end
        end
    end

    // monitor and check
    always @(posedge i_clk) begin
        t_pwm_setting want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (settings_due.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %0h",
                             $time, m_axis_tdata);
                    error_count++;
                end else begin
                    want = settings_due.pop_front();
                    check_field("prescaler", 32'(want.prescaler), 32'(m_axis_tdata[15:0]));
                    check_field("autoreload", want.autoreload, m_axis_tdata[47:16]);
                    check_field("compare", want.compare, m_axis_tdata[79:48]);
                    check_field("channel", 32'(want.channel), 32'(m_axis_tdata[81:80]));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                predict_setting({s_axis_tuser, s_axis_tdata[1:0], s_axis_tdata[29:2],
                                 s_axis_tdata[45:30]});
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        add_request(KIND_FREQ_KEEP, 2'd0, 28'd1000, 16'd12800);
        add_request(KIND_DUTY, 2'd1, 28'd0, 16'd12800);
        add_request(KIND_IDLE, 2'd2, 28'd5000, 16'd100);
        add_request(KIND_FREQ_DUTY, 2'd0, 28'd0, 16'(FULL_DUTY));
        add_request(KIND_FREQ_DUTY, 2'd1, 28'hFFFFFFF, 16'h7FFF);
        add_request(KIND_FREQ_DUTY, 2'd2, 28'd1000, 16'h8000);
        add_request(KIND_FREQ_DUTY, 2'd3, 28'd1282, 16'(FULL_DUTY) + 16'd1);
        add_request(KIND_FREQ_DUTY, 2'd3, 28'd1281, 16'hFFFF);
        add_request(KIND_DUTY, 2'd0, 28'hAAAAAAA, 16'd6400);
        add_request(KIND_FREQ_KEEP, 2'd0, 28'd20000, 16'h5555);
        add_request(KIND_FREQ_KEEP, 2'd1, 28'd1, 16'hAAAA);
        add_request(KIND_DUTY, 2'd2, 28'h5555555, 16'(FULL_DUTY));
        add_request(KIND_DUTY, 2'd3, 28'd0, 16'd0);
        add_request(KIND_IDLE, 2'd0, 28'hFFFFFFF, 16'hFFFF);
        add_request(KIND_FREQ_DUTY, 2'd0, 28'(CLOCK_RESET), 16'd12800);
        add_request(KIND_FREQ_KEEP, 2'd0, 28'd42000000, 16'd0);
        add_request(KIND_FREQ_DUTY, 2'd1, 28'd50, 16'd100);
        add_request(KIND_FREQ_KEEP, 2'd2, 28'd60, 16'd0);
        add_request(KIND_FREQ_KEEP, 2'd3, 28'd65536, 16'd0);
        add_request(KIND_FREQ_DUTY, 2'd2, 28'd2, 16'd1);
        hold_request <= 1'b1;
        add_random_requests(200);
        wait_idle();

        run_phase(28'd200000000, 1'b0, 180);
        run_phase(28'd200000000, 1'b1, 180);
        run_phase(28'd1, 1'b0, 60);
        run_phase(28'd0, 1'b1, 40);
        run_phase(28'hFFFFFFF, 1'b0, 150);
        steady_phase <= 1'b1;
        run_phase(CLOCK_RESET, 1'b0, 220);

        repeat (300) @(posedge i_clk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
